>>> hdl/nfa_pkg.sv
// Shared types and constants for the NFA epsilon symbol matcher.
// Used by every module under hdl; depends on nothing.
package nfa_pkg;

  localparam int NUM_STATES      = 16;
  localparam int NUM_TRANSITIONS = 64;

  localparam int STATE_W   = $clog2(NUM_STATES);
  localparam int SYM_W     = 8;
  localparam int IDX_W     = $clog2(NUM_TRANSITIONS);
  localparam int CNT_W     = 7;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Edge symbol that marks a move without input.
  localparam logic [SYM_W-1:0] EPSILON_SYM = 8'd61;

  typedef logic [NUM_STATES-1:0] state_set_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START  = 2'd0,
    REG_ACCEPT = 2'd1,
    REG_COUNT  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [STATE_W-1:0] src;
    logic [SYM_W-1:0]   sym;
    logic [STATE_W-1:0] dest;
  } edge_t;

  // Work request from the input channel to the sequencer.
  typedef struct packed {
    logic             start;
    logic             step;
    logic [SYM_W-1:0] symbol;
  } seq_req_t;

  // Finished state set from the sequencer.
  typedef struct packed {
    logic       valid;
    state_set_t set;
  } seq_res_t;

endpackage

>>> hdl/nfa_table.sv
// Transition table memory: one write port, one registered read port.
// Depends on nfa_pkg.
module nfa_table (
  input  logic                     clk,
  input  logic                     we,
  input  logic [nfa_pkg::IDX_W-1:0] waddr,
  input  nfa_pkg::edge_t           wdata,
  input  logic                     re,
  input  logic [nfa_pkg::IDX_W-1:0] raddr,
  output nfa_pkg::edge_t           rdata
);
  import nfa_pkg::*;

  edge_t mem [NUM_TRANSITIONS];
  edge_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/nfa_edge_unit.sv
// Shared edge compare unit: tests one table entry against a symbol and a state set.
// Depends on nfa_pkg.
module nfa_edge_unit (
  input  logic                     entry_valid,
  input  nfa_pkg::edge_t           entry,
  input  logic [nfa_pkg::SYM_W-1:0] match_sym,
  input  nfa_pkg::state_set_t      match_set,
  output nfa_pkg::state_set_t      hit
);
  import nfa_pkg::*;

  logic fire;

  // The edge fires when its symbol matches and its source state is active.
  assign fire = entry_valid && (entry.sym == match_sym) && match_set[entry.src];
  assign hit  = fire ? (state_set_t'(1) << entry.dest) : '0;

endmodule

>>> hdl/nfa_ctrl.sv
// Sequencer: sweeps the transition table pass by pass through the edge unit.
// Depends on nfa_pkg; drives nfa_table reads and consumes nfa_edge_unit hits.
module nfa_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nfa_pkg::seq_req_t            req,
  input  logic [nfa_pkg::STATE_W-1:0]  start_state,
  input  logic [nfa_pkg::CNT_W-1:0]    edge_count,
  input  logic                         res_ready,
  output logic                         idle,
  output logic                         rd_en,
  output logic [nfa_pkg::IDX_W-1:0]    rd_addr,
  output logic                         rd_pend,
  input  nfa_pkg::state_set_t          hit,
  output logic [nfa_pkg::SYM_W-1:0]    match_sym,
  output nfa_pkg::state_set_t          match_set,
  output nfa_pkg::seq_res_t            res
);
  import nfa_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic              mode_sym_r, mode_sym_nxt;
  logic [CNT_W-1:0]  addr_r, addr_nxt;
  logic [CNT_W-1:0]  limit_r, limit_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              changed_r, changed_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  state_set_t        cur_r, cur_nxt;
  state_set_t        acc_r, acc_nxt;

  logic              issue;
  logic              pass_done;
  logic [CNT_W-1:0]  limit_in;

  assign limit_in  = (edge_count > CNT_W'(NUM_TRANSITIONS)) ?
                     CNT_W'(NUM_TRANSITIONS) : edge_count;
  assign issue     = (state_r == ST_SWEEP) && (addr_r < limit_r);
  assign pass_done = (state_r == ST_SWEEP) && (addr_r == limit_r) && !rd_pend_r;

  assign idle      = (state_r == ST_IDLE);
  assign rd_en     = issue;
  assign rd_addr   = addr_r[IDX_W-1:0];
  assign rd_pend   = rd_pend_r;
  assign match_sym = mode_sym_r ? sym_r : EPSILON_SYM;
  assign match_set = mode_sym_r ? cur_r : acc_r;
  assign res.valid = (state_r == ST_DONE);
  assign res.set   = acc_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req.start || req.step) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (pass_done && !mode_sym_r && !changed_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    mode_sym_nxt = mode_sym_r;
    addr_nxt     = addr_r;
    limit_nxt    = limit_r;
    rd_pend_nxt  = 1'b0;
    changed_nxt  = changed_r;
    sym_nxt      = sym_r;
    cur_nxt      = cur_r;
    acc_nxt      = acc_r;
    case (state_r)
      ST_IDLE: begin
        addr_nxt    = '0;
        changed_nxt = 1'b0;
        limit_nxt   = limit_in;
        if (req.start) begin
          acc_nxt      = state_set_t'(1) << start_state;
          mode_sym_nxt = 1'b0;
        end else if (req.step) begin
          acc_nxt      = '0;
          mode_sym_nxt = 1'b1;
          sym_nxt      = req.symbol;
        end
      end
      ST_SWEEP: begin
        rd_pend_nxt = issue;
        if (issue) begin
          addr_nxt = addr_r + CNT_W'(1);
        end
        acc_nxt = acc_r | hit;
        if ((hit & ~acc_r) != '0) begin
          changed_nxt = 1'b1;
        end
        if (pass_done) begin
          // The symbol pass is followed by closure passes; a closure pass
          // that added a state is repeated.
          addr_nxt     = '0;
          changed_nxt  = 1'b0;
          mode_sym_nxt = 1'b0;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          cur_nxt = acc_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_pend_r <= 1'b0;
      cur_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      cur_r     <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_sym_r <= mode_sym_nxt;
    addr_r     <= addr_nxt;
    limit_r    <= limit_nxt;
    changed_r  <= changed_nxt;
    sym_r      <= sym_nxt;
    acc_r      <= acc_nxt;
  end

  a_closure_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && !mode_sym_r) |=> (($past(acc_r) & ~acc_r) == '0))
    else $error("closure pass dropped an active state");

  a_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == ST_SWEEP))
    else $error("table data returned outside a sweep");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res_ready) |=> $stable(acc_r))
    else $error("finished set changed while waiting for the output slot");

endmodule

>>> hdl/nfa_epsilon_symbol_matcher.sv
// Top level of the NFA epsilon symbol matcher: ports, configuration registers,
// result register. Depends on nfa_pkg, nfa_table, nfa_edge_unit and nfa_ctrl.
//
//   Channel   Direction   Handshake            Payload
//   in_*      input       in_valid/in_ready    cmd, entry_index/src/symbol/dest, symbol
//   out_*     output      out_valid/out_ready  accepted, active_states
//   cfg_*     input       cfg_we               cfg_index, cfg_wdata
//
// A write item (and an unknown command) leaves the sequencer idle. A begin or
// symbol item sweeps the transition table once per pass through one shared
// edge compare unit, one entry per cycle over the entries in use. A symbol
// item runs one symbol pass, then closure passes until one adds no state,
// at most 17 passes in all.
// Reset is synchronous and clears the active set, the sequencer state, the
// configuration registers and the output valid flag; the table holds garbage
// until written. The block takes the next item as soon as the sequencer is
// idle, even while a result waits in the output register; a finished set waits
// in the sequencer only when that register is still full.
module nfa_epsilon_symbol_matcher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic [nfa_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [nfa_pkg::STATE_W-1:0]   in_entry_src,
  input  logic [nfa_pkg::SYM_W-1:0]     in_entry_symbol,
  input  logic [nfa_pkg::STATE_W-1:0]   in_entry_dest,
  input  logic [nfa_pkg::SYM_W-1:0]     in_symbol,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic [nfa_pkg::NUM_STATES-1:0] out_active_states,
  input  logic                          cfg_we,
  input  logic [nfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nfa_pkg::CFG_W-1:0]     cfg_wdata
);
  import nfa_pkg::*;

  // Configuration registers.
  logic [STATE_W-1:0] start_state_r;
  state_set_t         accept_mask_r;
  logic [CNT_W-1:0]   edge_count_r;

  // Output register.
  logic       out_valid_r;
  logic       out_accepted_r;
  state_set_t out_set_r;

  logic       in_fire;
  logic       tbl_we;
  edge_t      tbl_wdata;
  edge_t      tbl_rdata;
  logic       rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic       rd_pend;
  logic       ctrl_idle;
  logic       res_ready;
  seq_req_t   req;
  seq_res_t   res;
  state_set_t hit;
  logic [SYM_W-1:0] match_sym;
  state_set_t match_set;

  assign in_ready = ctrl_idle;
  assign in_fire  = in_valid && in_ready;

  // Table writes happen straight from the input channel.
  assign tbl_we         = in_fire && (in_cmd == CMD_WRITE);
  assign tbl_wdata.src  = in_entry_src;
  assign tbl_wdata.sym  = in_entry_symbol;
  assign tbl_wdata.dest = in_entry_dest;

  // Begin and symbol items start the sequencer; the unused code is dropped.
  assign req.start  = in_fire && (in_cmd == CMD_BEGIN);
  assign req.step   = in_fire && (in_cmd == CMD_STEP);
  assign req.symbol = in_symbol;

  // The sequencer may hand over its set when the output slot is free or
  // is being emptied in this cycle.
  assign res_ready = !out_valid_r || out_ready;

  nfa_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_entry_index),
    .wdata (tbl_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (tbl_rdata)
  );

  nfa_edge_unit u_edge (
    .entry_valid (rd_pend),
    .entry       (tbl_rdata),
    .match_sym   (match_sym),
    .match_set   (match_set),
    .hit         (hit)
  );

  nfa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .start_state (start_state_r),
    .edge_count  (edge_count_r),
    .res_ready   (res_ready),
    .idle        (ctrl_idle),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_pend     (rd_pend),
    .hit         (hit),
    .match_sym   (match_sym),
    .match_set   (match_set),
    .res         (res)
  );

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      accept_mask_r <= '0;
      edge_count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START:  start_state_r <= cfg_wdata[STATE_W-1:0];
        REG_ACCEPT: accept_mask_r <= cfg_wdata[NUM_STATES-1:0];
        REG_COUNT:  edge_count_r  <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The accept flag is taken with the set, against the mask that is in
  // force when the sequencer hands the set over.
  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_set_r      <= res.set;
      out_accepted_r <= |(res.set & accept_mask_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_active_states = out_set_r;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (req.start || req.step) |=> !in_ready)
    else $error("input taken while a begin or symbol item is running");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_active_states) && $stable(out_accepted)))
    else $error("waiting result changed before it was taken");

  a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> ctrl_idle)
    else $error("table written while the sequencer is busy");

endmodule
